// ===== sv/rxp_pkg.sv =====
// ----------------------------------------------------------------------------
// rxp_pkg
// Shared types, character codes and helpers for the regex infix-to-postfix
// converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rxp_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int MAX_RESULTS = 40;
   localparam int STACK_IDX_W = $clog2(STACK_DEPTH);
   localparam int STACK_CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int RESULT_CNT_W = $clog2(MAX_RESULTS + 1);

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_ALT   = 8'h7C;
   localparam logic [7:0] CH_CAT   = 8'h2E;
   localparam logic [7:0] CH_OPEN  = 8'h28;
   localparam logic [7:0] CH_CLOSE = 8'h29;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_OVERFLOW   = 2'd1;
   localparam logic [1:0] ST_UNMATCHED  = 2'd2;

   // Operator code doubles as its precedence
   typedef enum logic [1:0] {
      OP_OPEN = 2'd0,
      OP_ALT  = 2'd1,
      OP_CAT  = 2'd2,
      OP_STAR = 2'd3
   } op_code_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_POP_ALT,
      S_POP_CLOSE,
      S_CAT,
      S_FLUSH
   } seq_state_type;

   typedef struct packed {
      logic        push;
      logic        pop;
      op_code_type code;
   } stack_ctl_type;

   function automatic logic [7:0] code_sym(input op_code_type code);
      logic [7:0] sym;
      unique case (code)
         OP_OPEN: sym = CH_OPEN;
         OP_ALT:  sym = CH_ALT;
         OP_CAT:  sym = CH_CAT;
         OP_STAR: sym = CH_STAR;
         default: sym = CH_NUL;
      endcase
      return sym;
   endfunction

endpackage

`default_nettype wire

// ===== sv/rxp_req_if.sv =====
// ----------------------------------------------------------------------------
// rxp_req_if
// Input channel: one regex character and its lookahead per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface rxp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic [7:0] next_ch;

   modport source (output valid, output ch, output next_ch, input ready);
   modport sink   (input valid, input ch, input next_ch, output ready);
endinterface

`default_nettype wire

// ===== sv/rxp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rxp_rsp_if
// Result channel: one postfix symbol with end flag and status per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface rxp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] sym;
   logic       end_of_expr;
   logic [1:0] status;

   modport source (output valid, output sym, output end_of_expr, output status,
                   input ready);
   modport sink   (input valid, input sym, input end_of_expr, input status,
                   output ready);
endinterface

`default_nettype wire

// ===== sv/regex_infix_to_postfix_unit.sv =====
// ----------------------------------------------------------------------------
// regex_infix_to_postfix_unit
// Shunting-yard conversion of a regular expression to postfix form.
// ----------------------------------------------------------------------------
// One character (with its lookahead) is taken per transaction when req_chan
// is ready. A small sequencer then works through it, one step a cycle: a
// dispatch step, one step per operator popped from the stack, one more step
// for an alternation (its push) or a closing parenthesis (dropping the open
// parenthesis or flagging it unmatched), a step for the implicit
// concatenation, and when the lookahead is zero one step per flushed
// operator plus one for the terminator. Every step is a single compare
// against the stack top and the result register, so a stalled result side
// holds the sequencer.
// Results go out through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module regex_infix_to_postfix_unit
   import rxp_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   rxp_req_if.sink   req_chan,
   rxp_rsp_if.source rsp_chan
);

   seq_state_type           state_ff, state_in;
   logic [7:0]              ch_ff, nx_ff;
   logic                    cat_after_ff, cat_need_ff;
   logic                    cat_after_c, cat_need_c;

   logic                    rsp_valid_ff;
   logic [7:0]              rsp_sym_ff;
   logic                    rsp_end_ff;
   logic [1:0]              rsp_status_ff;
   logic [RESULT_CNT_W-1:0] res_cnt_ff;

   stack_ctl_type           ctl;
   logic [STACK_CNT_W-1:0]  count;
   op_code_type             top;
   logic                    empty, full;

   logic                    accept, step;
   logic                    emit;
   logic [7:0]              emit_sym;
   logic                    emit_end;
   logic [1:0]              emit_status;

   rxp_opstack u_opstack (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .count (count),
      .top   (top)
   );

   assign empty = (count == '0);
   assign full  = (count >= STACK_CNT_W'(STACK_DEPTH));

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   // hold the sequencer while a result waits
   assign step           = (state_ff != S_IDLE) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      cat_after_c = (req_chan.ch != CH_ALT) && (req_chan.ch != CH_CLOSE) &&
                    (req_chan.ch != CH_OPEN) && (req_chan.next_ch != CH_ALT) &&
                    (req_chan.next_ch != CH_CLOSE) && (req_chan.next_ch != CH_STAR) &&
                    (req_chan.next_ch != CH_NUL);
      cat_need_c  = cat_after_c ||
                    ((req_chan.ch == CH_CLOSE) && (req_chan.next_ch != CH_CLOSE) &&
                     (req_chan.next_ch != CH_STAR) && (req_chan.next_ch != CH_ALT) &&
                     (req_chan.next_ch != CH_NUL));
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ch_ff        <= req_chan.ch;
         nx_ff        <= req_chan.next_ch;
         cat_after_ff <= cat_after_c;
         cat_need_ff  <= cat_need_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      ctl         = '{push: 1'b0, pop: 1'b0, code: OP_OPEN};
      emit        = 1'b0;
      emit_sym    = CH_NUL;
      emit_end    = 1'b0;
      emit_status = ST_OK;

      if (accept) begin
         state_in = S_DISPATCH;
      end

      if (step) begin
         unique case (state_ff)
            S_DISPATCH: begin
               priority if (ch_ff == CH_NUL) begin
                  state_in = S_FLUSH;
               end else if (ch_ff == CH_ALT) begin
                  state_in = S_POP_ALT;
               end else if (ch_ff == CH_CLOSE) begin
                  state_in = S_POP_CLOSE;
               end else if (ch_ff == CH_STAR && cat_after_ff) begin
                  emit     = 1'b1;
                  emit_sym = CH_STAR;
                  state_in = S_CAT;
               end else if (ch_ff == CH_STAR || ch_ff == CH_OPEN) begin
                  ctl.code = (ch_ff == CH_STAR) ? OP_STAR : OP_OPEN;
                  if (full) begin
                     emit        = 1'b1;
                     emit_sym    = code_sym(ctl.code);
                     emit_status = ST_OVERFLOW;
                  end else begin
                     ctl.push = 1'b1;
                  end
                  state_in = S_CAT;
               end else begin
                  emit     = 1'b1;
                  emit_sym = ch_ff;
                  state_in = S_CAT;
               end
            end
            S_POP_ALT: begin
               if (!empty && top > OP_ALT) begin
                  ctl.pop  = 1'b1;
                  emit     = 1'b1;
                  emit_sym = code_sym(top);
               end else begin
                  ctl.code = OP_ALT;
                  if (full) begin
                     emit        = 1'b1;
                     emit_sym    = CH_ALT;
                     emit_status = ST_OVERFLOW;
                  end else begin
                     ctl.push = 1'b1;
                  end
                  state_in = S_CAT;
               end
            end
            S_POP_CLOSE: begin
               priority if (!empty && top != OP_OPEN) begin
                  ctl.pop  = 1'b1;
                  emit     = 1'b1;
                  emit_sym = code_sym(top);
               end else if (empty) begin
                  emit        = 1'b1;
                  emit_sym    = CH_CLOSE;
                  emit_status = ST_UNMATCHED;
                  state_in    = S_CAT;
               end else begin
                  // drop the matching open parenthesis
                  ctl.pop  = 1'b1;
                  state_in = S_CAT;
               end
            end
            S_CAT: begin
               if (cat_need_ff) begin
                  ctl.code = OP_CAT;
                  if (full) begin
                     emit        = 1'b1;
                     emit_sym    = CH_CAT;
                     emit_status = ST_OVERFLOW;
                  end else begin
                     ctl.push = 1'b1;
                  end
               end
               state_in = (nx_ff == CH_NUL) ? S_FLUSH : S_IDLE;
            end
            S_FLUSH: begin
               if (!empty) begin
                  ctl.pop  = 1'b1;
                  emit     = 1'b1;
                  emit_sym = code_sym(top);
               end else begin
                  emit     = 1'b1;
                  emit_sym = CH_NUL;
                  emit_end = 1'b1;
                  state_in = S_IDLE;
               end
            end
            default: begin
               state_in = S_IDLE;
            end
         endcase
      end
   end

   // results beyond the per-character cap are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         res_cnt_ff   <= '0;
      end else begin
         if (accept) begin
            res_cnt_ff <= '0;
         end
         if (emit && res_cnt_ff < RESULT_CNT_W'(MAX_RESULTS)) begin
            rsp_valid_ff <= 1'b1;
            res_cnt_ff   <= res_cnt_ff + RESULT_CNT_W'(1);
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit && res_cnt_ff < RESULT_CNT_W'(MAX_RESULTS)) begin
         rsp_sym_ff    <= emit_sym;
         rsp_end_ff    <= emit_end;
         rsp_status_ff <= emit_status;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.sym         = rsp_sym_ff;
   assign rsp_chan.end_of_expr = rsp_end_ff;
   assign rsp_chan.status      = rsp_status_ff;

endmodule

`default_nettype wire

// ===== sv/rxp_opstack.sv =====
// ----------------------------------------------------------------------------
// rxp_opstack
// Operator stack: push and pop one entry a cycle, top entry visible.
// ----------------------------------------------------------------------------
`default_nettype none

module rxp_opstack
   import rxp_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire stack_ctl_type          ctl,
   output      logic [STACK_CNT_W-1:0] count,
   output      op_code_type            top
);

   op_code_type            stack_ff [STACK_DEPTH];
   logic [STACK_CNT_W-1:0] count_ff;
   logic [STACK_CNT_W-1:0] count_in;
   logic [STACK_CNT_W-1:0] top_pos;

   always_comb begin
      count_in = count_ff;
      if (ctl.push) begin
         count_in = count_ff + STACK_CNT_W'(1);
      end else if (ctl.pop) begin
         count_in = count_ff - STACK_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // storage needs no reset: only entries below the count are read
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         stack_ff[count_ff[STACK_IDX_W-1:0]] <= ctl.code;
      end
   end

   assign top_pos = count_ff - STACK_CNT_W'(1);
   assign top     = stack_ff[top_pos[STACK_IDX_W-1:0]];
   assign count   = count_ff;

endmodule

`default_nettype wire

// ===== verif/tb_regex_infix_to_postfix_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_regex_infix_to_postfix_unit
// Self-checking bench for the regex infix-to-postfix converter. Characters
// with their lookahead are sent from a queue of pending transactions. Each
// accepted character runs through a shunting-yard predictor kept in the
// bench. Every postfix symbol that comes out is compared in order with the
// predicted one. Both channels stall at random.
// ----------------------------------------------------------------------------

module tb_regex_infix_to_postfix_unit;
   import rxp_pkg::*;

   typedef struct packed {
      logic [7:0] sym;
      logic       end_of_expr;
      logic [1:0] status;
   } postfix_entry_type;

   typedef struct {
      logic [7:0] ch;
      logic [7:0] next_ch;
      logic       drain;
   } char_item_type;

   logic clock;
   logic reset;

   rxp_req_if req_chan ();
   rxp_rsp_if rsp_chan ();

   regex_infix_to_postfix_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Stimulus and expectation stores
   char_item_type     pending_chars[$];
   postfix_entry_type postfix_q[$];
   logic [7:0]        text_q[$];

   // Predictor state
   op_code_type op_stack_m[STACK_DEPTH];
   int          op_depth;
   int          step_results;

   int          mismatches;
   int          cycle_cnt;
   logic        req_taken;
   postfix_entry_type seen_entry;
   postfix_entry_type wanted_entry;

   // ---------------------------------------------------------------------
   // Shunting-yard predictor
   // ---------------------------------------------------------------------
   function automatic logic [7:0] op_char(input op_code_type code);
      logic [7:0] c;
      case (code)
         OP_OPEN: c = CH_OPEN;
         OP_ALT:  c = CH_ALT;
         OP_CAT:  c = CH_CAT;
         default: c = CH_STAR;
      endcase
      return c;
   endfunction

   task automatic emit_result(input logic [7:0] sym, input logic fin, input logic [1:0] st);
      postfix_entry_type e;
      // drop anything past the per-character result limit
      if (step_results < MAX_RESULTS) begin
         e.sym         = sym;
         e.end_of_expr = fin;
         e.status      = st;
         postfix_q.push_back(e);
         step_results++;
      end
   endtask

   task automatic pop_operator();
      op_depth--;
      emit_result(op_char(op_stack_m[op_depth]), 1'b0, ST_OK);
   endtask

   task automatic push_operator(input op_code_type code);
      if (op_depth >= STACK_DEPTH) begin
         emit_result(op_char(code), 1'b0, ST_OVERFLOW);
      end else begin
         op_stack_m[op_depth] = code;
         op_depth++;
      end
   endtask

   task automatic flush_operators();
      while (op_depth > 0) pop_operator();
      emit_result(CH_NUL, 1'b1, ST_OK);
   endtask

   task automatic convert_char(input logic [7:0] c, input logic [7:0] nx);
      logic cat_after;
      step_results = 0;
      if (c == CH_NUL) begin
         flush_operators();
      end else begin
         cat_after = c != CH_ALT && c != CH_CLOSE && c != CH_OPEN &&
                     nx != CH_ALT && nx != CH_CLOSE && nx != CH_STAR && nx != CH_NUL;
         case (c)
            CH_ALT: begin
               while (op_depth > 0 && op_stack_m[op_depth-1] > OP_ALT) pop_operator();
               push_operator(OP_ALT);
            end
            CH_STAR: begin
               // a star followed by concatenation goes straight out
               if (cat_after) emit_result(CH_STAR, 1'b0, ST_OK);
               else push_operator(OP_STAR);
            end
            CH_OPEN: push_operator(OP_OPEN);
            CH_CLOSE: begin
               while (op_depth > 0 && op_stack_m[op_depth-1] != OP_OPEN) pop_operator();
               if (op_depth == 0) emit_result(CH_CLOSE, 1'b0, ST_UNMATCHED);
               else op_depth--;
            end
            default: emit_result(c, 1'b0, ST_OK);
         endcase
         if (cat_after || (c == CH_CLOSE && nx != CH_CLOSE && nx != CH_STAR &&
                           nx != CH_ALT && nx != CH_NUL))
            push_operator(OP_CAT);
         if (nx == CH_NUL) flush_operators();
      end
   endtask

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic logic [7:0] rand_literal();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255));
      while (c == CH_STAR || c == CH_ALT || c == CH_OPEN || c == CH_CLOSE);
      return c;
   endfunction

   task automatic add_char(input logic [7:0] c, input logic [7:0] nx, input logic drain);
      char_item_type it;
      it.ch      = c;
      it.next_ch = nx;
      it.drain   = drain;
      pending_chars.push_back(it);
   endtask

   // Send text_q as one expression, each character with its lookahead
   task automatic queue_text(input logic drain);
      for (int i = 0; i < text_q.size(); i++)
         add_char(text_q[i], (i + 1 < text_q.size()) ? text_q[i+1] : CH_NUL,
                  drain && i == 0);
   endtask

   task automatic load_text(input string s);
      text_q.delete();
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endtask

   task automatic build_regex(input int len);
      int depth;
      int roll;
      logic operand;
      text_q.delete();
      depth   = 0;
      operand = 1'b0;
      repeat (len) begin
         roll = $urandom_range(99);
         if (operand && roll < 20) begin
            text_q.push_back(CH_STAR);
         end else if (operand && roll < 35) begin
            text_q.push_back(CH_ALT);
            operand = 1'b0;
         end else if (operand && depth > 0 && roll < 50) begin
            text_q.push_back(CH_CLOSE);
            depth--;
         end else if (roll < 62) begin
            text_q.push_back(CH_OPEN);
            depth++;
            operand = 1'b0;
         end else begin
            text_q.push_back(rand_literal());
            operand = 1'b1;
         end
      end
      if (!operand) text_q.push_back(rand_literal());
      repeat (depth) text_q.push_back(CH_CLOSE);
      // occasionally break the expression
      roll = $urandom_range(19);
      if (roll == 0) text_q.push_front(CH_CLOSE);
      else if (roll == 1) text_q.push_front(CH_OPEN);
      else if (roll == 2) text_q.push_back(CH_STAR);
   endtask

   task automatic note_mismatch(input string what, input postfix_entry_type want,
                                input postfix_entry_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%t %s: expected sym %h end %b status %0d, got sym %h end %b status %0d",
                  $realtime, what, want.sym, want.end_of_expr, want.status,
                  got.sym, got.end_of_expr, got.status);
   endtask

   function automatic logic take_break();
      logic calm;
      calm = cycle_cnt >= 400 && cycle_cnt < 900;
      return !calm && ($urandom_range(99) < 27);
   endfunction

   // ---------------------------------------------------------------------
   // Clock, reset and stimulus
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      int sent;
      int roll;
      int n;
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.ch      = 8'h00;
      req_chan.next_ch = 8'h00;
      rsp_chan.ready   = 1'b0;
      mismatches       = 0;
      op_depth         = 0;
      req_taken        = 1'b0;

      // directed expressions
      load_text("a*b");     queue_text(1'b0);
      load_text("(a|b)*c"); queue_text(1'b0);
      load_text("a|b|c");   queue_text(1'b0);
      load_text("x)y");     queue_text(1'b0);
      load_text("(a.");     queue_text(1'b0);
      add_char(8'hFF, 8'h01, 1'b0);
      add_char(8'h01, CH_NUL, 1'b0);
      // zero character ends the expression with operators still stacked
      add_char(CH_OPEN, CH_OPEN, 1'b0);
      add_char(CH_NUL, 8'h41, 1'b0);

      sent = 0;
      while (sent < 460) begin
         roll = $urandom_range(99);
         if (roll < 65) begin
            build_regex(($urandom_range(9) == 0) ? $urandom_range(15, 30)
                                                 : $urandom_range(1, 10));
            queue_text(sent == 0 || $urandom_range(49) == 0);
            sent += text_q.size();
         end else if (roll < 75) begin
            // deep stack: nested opens or a long concatenation chain
            text_q.delete();
            n = $urandom_range(28, 38);
            if ($urandom_range(1) == 0) begin
               repeat (n) text_q.push_back(CH_OPEN);
               text_q.push_back(rand_literal());
            end else begin
               repeat (n) text_q.push_back(rand_literal());
            end
            queue_text(1'b0);
            sent += text_q.size();
         end else begin
            add_char(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)), 1'b0);
            sent++;
         end
      end
      // close off whatever the noise left behind
      load_text("z");
      queue_text(1'b1);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      do @(posedge clock);
      while (pending_chars.size() != 0 || req_chan.valid || postfix_q.size() != 0);
      repeat (200) @(posedge clock);

      if (postfix_q.size() != 0) begin
         mismatches += postfix_q.size();
         $display("%0d expected results never arrived", postfix_q.size());
      end
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) cycle_cnt <= 0;
      else cycle_cnt <= cycle_cnt + 1;
   end

   // ---------------------------------------------------------------------
   // Driver: present a new transaction once the previous one is taken
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_chan.valid || req_taken) begin
            req_taken = 1'b0;
            // hold drain-marked characters until all results are back
            if (pending_chars.size() != 0 &&
                (!pending_chars[0].drain || postfix_q.size() == 0) && !take_break()) begin
               req_chan.valid   <= 1'b1;
               req_chan.ch      <= pending_chars[0].ch;
               req_chan.next_ch <= pending_chars[0].next_ch;
               void'(pending_chars.pop_front());
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
         rsp_chan.ready <= !take_break();
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: predict on accepted characters, check each postfix symbol
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            convert_char(req_chan.ch, req_chan.next_ch);
            req_taken = 1'b1;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen_entry.sym         = rsp_chan.sym;
            seen_entry.end_of_expr = rsp_chan.end_of_expr;
            seen_entry.status      = rsp_chan.status;
            if (postfix_q.size() == 0) begin
               note_mismatch("unexpected result", seen_entry, seen_entry);
            end else begin
               wanted_entry = postfix_q.pop_front();
               if (seen_entry.sym != wanted_entry.sym ||
                   seen_entry.end_of_expr != wanted_entry.end_of_expr ||
                   seen_entry.status != wanted_entry.status)
                  note_mismatch("result mismatch", wanted_entry, seen_entry);
            end
         end
      end
   end

endmodule
